FILE: rtl/qpot_pkg.sv
package qpot_pkg;

  // Queue geometry.
  localparam int QueueDepth = 1024;
  localparam int SlotW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int OccW       = $clog2(QueueDepth + 1);

  // Request and result field widths.
  localparam int OpW    = 2;
  localparam int LenW   = 32;
  localparam int EntryW = 11;
  localparam int StW    = 2;
  localparam int PosW   = 64;

  // Width that holds both an entry number and an occupancy, and one more bit for sums.
  localparam int WideW = (OccW > EntryW) ? OccW : EntryW;
  localparam int SumW  = WideW + 1;

  // Depth of the command queue between the front and the back part.
  localparam int CmdQDepth = 2;
  localparam int CmdQPtrW  = $clog2(CmdQDepth);
  localparam int CmdQCntW  = $clog2(CmdQDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Classified command handed from the front to the back part.
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_QUERY,
    CMD_BAD
  } cmd_kind_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [LenW-1:0]   length;
    logic [EntryW-1:0] entry_number;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] start_position;
  } rsp_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [LenW-1:0]   length;
    logic [EntryW-1:0] entry_number;
  } cmd_t;

  // Status of the back part, watched at the top level.
  typedef struct packed {
    logic [OccW-1:0] occupancy;
  } bk_stat_t;

  // Ring successor of a slot index.
  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = s + SlotW'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/qpot_front.sv
module qpot_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  qpot_pkg::req_t   req_i,
  output qpot_pkg::cmd_t   cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i
);

  qpot_pkg::cmd_t                      cmdq_q [qpot_pkg::CmdQDepth];
  logic [qpot_pkg::CmdQPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [qpot_pkg::CmdQPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [qpot_pkg::CmdQCntW-1:0]       cnt_q, cnt_d;
  qpot_pkg::cmd_t                      cmd_new;
  logic                                push;

  // Classify the incoming request; an unused code or a query for entry zero is rejected later.
  always_comb begin
    cmd_new.length       = req_i.length;
    cmd_new.entry_number = req_i.entry_number;
    unique case (req_i.operation)
      qpot_pkg::OP_PUSH: begin
        cmd_new.kind = qpot_pkg::CMD_PUSH;
      end
      qpot_pkg::OP_POP: begin
        cmd_new.kind = qpot_pkg::CMD_POP;
      end
      qpot_pkg::OP_QUERY: begin
        cmd_new.kind = (req_i.entry_number == '0) ? qpot_pkg::CMD_BAD
                                                  : qpot_pkg::CMD_QUERY;
      end
      default: begin
        cmd_new.kind = qpot_pkg::CMD_BAD;
      end
    endcase
  end

  assign busy        = (cnt_q == qpot_pkg::CmdQCntW'(qpot_pkg::CmdQDepth));
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmdq_q[rd_ptr_q];

  // Pointer and count updates of the command queue.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == qpot_pkg::CmdQPtrW'(qpot_pkg::CmdQDepth - 1)) ? '0
                 : wr_ptr_q + qpot_pkg::CmdQPtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == qpot_pkg::CmdQPtrW'(qpot_pkg::CmdQDepth - 1)) ? '0
                 : rd_ptr_q + qpot_pkg::CmdQPtrW'(1);
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + qpot_pkg::CmdQCntW'(1);
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - qpot_pkg::CmdQCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmdq_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: rtl/qpot_back.sv
module qpot_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qpot_pkg::cmd_t     cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               done_o,
  output qpot_pkg::rsp_t     rsp_o,
  output qpot_pkg::bk_stat_t stat_o
);

  typedef enum logic {
    S_EXEC,
    S_FINISH
  } state_e;

  state_e                           state_q, state_d;
  logic [qpot_pkg::PosW-1:0]        offset_mem_q [qpot_pkg::QueueDepth];
  logic [qpot_pkg::PosW-1:0]        rd_data_q;
  logic [qpot_pkg::PosW-1:0]        running_total_q, running_total_d;
  logic [qpot_pkg::PosW-1:0]        head_base_q, head_base_d;
  logic [qpot_pkg::SlotW-1:0]       head_q, head_d;
  logic [qpot_pkg::SlotW-1:0]       tail_q, tail_d;
  logic [qpot_pkg::OccW-1:0]        occ_q, occ_d;
  logic                             pend_pop_q, pend_pop_d;
  logic                             done_q, done_d;
  qpot_pkg::rsp_t                   rsp_q, rsp_d;
  logic                             mem_we;
  logic [qpot_pkg::SlotW-1:0]       rd_addr;
  logic [qpot_pkg::WideW-1:0]       k_w, occ_w, k_m1;
  logic [qpot_pkg::SumW-1:0]        slot_sum;
  logic [qpot_pkg::SlotW-1:0]       query_slot;
  logic                             q_in_range;
  logic [qpot_pkg::SlotW-1:0]       head_next;
  logic [qpot_pkg::OccW-1:0]        occ_dec;

  // Slot of the queried entry: head plus entry number minus one, wrapped once.
  always_comb begin
    k_w        = qpot_pkg::WideW'(cmd_i.entry_number);
    occ_w      = qpot_pkg::WideW'(occ_q);
    k_m1       = k_w - qpot_pkg::WideW'(1);
    q_in_range = (k_w <= occ_w);
    slot_sum   = qpot_pkg::SumW'(head_q) + qpot_pkg::SumW'(k_m1);
    if (slot_sum >= qpot_pkg::SumW'(qpot_pkg::QueueDepth)) begin
      slot_sum = slot_sum - qpot_pkg::SumW'(qpot_pkg::QueueDepth);
    end
    query_slot = slot_sum[qpot_pkg::SlotW-1:0];
    head_next  = qpot_pkg::next_slot(head_q);
    occ_dec    = occ_q - qpot_pkg::OccW'(1);
  end

  assign rd_addr   = (cmd_i.kind == qpot_pkg::CMD_POP) ? head_next : query_slot;
  assign cmd_pop_o = (state_q == S_EXEC) && cmd_valid_i;
  assign mem_we    = cmd_pop_o && (cmd_i.kind == qpot_pkg::CMD_PUSH)
                     && (occ_q != qpot_pkg::OccW'(qpot_pkg::QueueDepth));

  // Command execution: pushes, rejects and emptying pops finish in S_EXEC, reads in S_FINISH.
  always_comb begin
    state_d         = state_q;
    running_total_d = running_total_q;
    head_base_d     = head_base_q;
    head_d          = head_q;
    tail_d          = tail_q;
    occ_d           = occ_q;
    pend_pop_d      = pend_pop_q;
    done_d          = 1'b0;
    rsp_d           = rsp_q;
    unique case (state_q)
      S_EXEC: begin
        if (cmd_valid_i) begin
          rsp_d.start_position = '0;
          rsp_d.status         = qpot_pkg::ST_EMPTY;
          case (cmd_i.kind)
            qpot_pkg::CMD_PUSH: begin
              done_d = 1'b1;
              if (occ_q == qpot_pkg::OccW'(qpot_pkg::QueueDepth)) begin
                rsp_d.status = qpot_pkg::ST_FULL;
              end else begin
                running_total_d = running_total_q + qpot_pkg::PosW'(cmd_i.length);
                tail_d          = qpot_pkg::next_slot(tail_q);
                occ_d           = occ_q + qpot_pkg::OccW'(1);
                rsp_d.status    = qpot_pkg::ST_OK;
              end
            end
            qpot_pkg::CMD_POP: begin
              if (occ_q == '0) begin
                done_d = 1'b1;
              end else begin
                head_d = head_next;
                occ_d  = occ_dec;
                if (occ_dec == '0) begin
                  head_base_d  = running_total_q;
                  rsp_d.status = qpot_pkg::ST_OK;
                  done_d       = 1'b1;
                end else begin
                  pend_pop_d = 1'b1;
                  state_d    = S_FINISH;
                end
              end
            end
            qpot_pkg::CMD_QUERY: begin
              if (q_in_range) begin
                pend_pop_d = 1'b0;
                state_d    = S_FINISH;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_FINISH: begin
        done_d       = 1'b1;
        rsp_d.status = qpot_pkg::ST_OK;
        if (pend_pop_q) begin
          head_base_d          = rd_data_q;
          rsp_d.start_position = '0;
        end else begin
          rsp_d.start_position = rd_data_q - head_base_q;
        end
        state_d = S_EXEC;
      end
      default: begin
        state_d = S_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_EXEC;
      running_total_q <= '0;
      head_base_q     <= '0;
      head_q          <= '0;
      tail_q          <= '0;
      occ_q           <= '0;
      pend_pop_q      <= 1'b0;
      done_q          <= 1'b0;
      rsp_q           <= '{status: qpot_pkg::ST_OK, start_position: '0};
    end else begin
      state_q         <= state_d;
      running_total_q <= running_total_d;
      head_base_q     <= head_base_d;
      head_q          <= head_d;
      tail_q          <= tail_d;
      occ_q           <= occ_d;
      pend_pop_q      <= pend_pop_d;
      done_q          <= done_d;
      rsp_q           <= rsp_d;
    end
  end

  // Offset memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      offset_mem_q[tail_q] <= running_total_q;
    end
    rd_data_q <= offset_mem_q[rd_addr];
  end

  assign done_o           = done_q;
  assign rsp_o            = rsp_q;
  assign stat_o.occupancy = occ_q;

endmodule

FILE: rtl/queue_prefix_offset_tracker_unit.sv
// Length queue with start offset lookup.
// A request is taken at a rising edge where start is high and busy is low:
// start and busy form the command handshake, req_i carries the operation, the
// pushed length and the 1-based entry number. Push appends a length, pop drops
// the head, query returns the summed length of the items ahead of that entry.
// Each result is valid on rsp_o while done_o is high, for exactly one cycle; the
// receiver cannot stall, so results are never held back.
// A two-entry command queue decouples request intake from execution, and busy
// is high only while that queue is full.
// An accepted request waits in the command queue. A push, a rejected request or
// a pop that empties the ring completes in the execute state; an in-range query
// or a pop that leaves items queued reads the offset memory and completes in the
// finish state. The first kinds are taken one per cycle while queued; a read
// holds the next request back until the registered memory read is done.
// Reset clears the queue pointers, occupancy and running totals at once; the
// offset memory is not cleared, and only written slots are ever used.
module queue_prefix_offset_tracker_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  qpot_pkg::req_t req_i,
  output logic           done_o,
  output qpot_pkg::rsp_t rsp_o
);

  qpot_pkg::cmd_t     cmd;
  logic               cmd_valid;
  logic               cmd_pop;
  qpot_pkg::bk_stat_t stat;

  // Intake and classification.
  qpot_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Execution against the offset ring.
  qpot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .stat_o      (stat)
  );

  // The occupancy never exceeds the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.occupancy <= qpot_pkg::OccW'(qpot_pkg::QueueDepth))
    else $error("occupancy exceeds queue depth");

  // A failing result always reports a zero position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != qpot_pkg::ST_OK) |-> rsp_o.start_position == '0)
    else $error("nonzero position on a failing result");

  // A full status is only reported while the ring is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == qpot_pkg::ST_FULL)
      |-> stat.occupancy == qpot_pkg::OccW'(qpot_pkg::QueueDepth))
    else $error("full status while ring has room");

endmodule

FILE: tb/qpot_checker.sv
`timescale 1ns / 100ps

module qpot_checker
  import qpot_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  rsp_t        rsp_i,
  output int unsigned pending_o,
  output int unsigned failures_o,
  output int unsigned checked_o,
  output int unsigned full_seen_o,
  output int unsigned reject_seen_o
);

  // Shadow of the queue: start offset per ring slot and the running sums.
  logic [PosW-1:0] slot_start [QueueDepth];
  logic [PosW-1:0] total_len;
  logic [PosW-1:0] head_start;
  int unsigned     head_ix;
  int unsigned     tail_ix;
  int unsigned     fill;

  // Responses owed by the block, oldest first.
  rsp_t owed_rsp_q[$];

  // One line per mismatch, and the mismatch is counted.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    failures_o++;
  endtask

  // Applies one request to the shadow queue and returns the response it owes.
  function automatic rsp_t track_offset(input req_t r);
    rsp_t        o;
    int unsigned ix;
    o.status         = ST_EMPTY;
    o.start_position = '0;
    case (r.operation)
      OP_PUSH: begin
        if (fill >= QueueDepth) begin
          o.status = ST_FULL;
        end else begin
          slot_start[tail_ix] = total_len;
          total_len           = total_len + PosW'(r.length);
          tail_ix             = (tail_ix + 1) % QueueDepth;
          fill++;
          o.status = ST_OK;
        end
      end
      OP_POP: begin
        if (fill != 0) begin
          head_ix = (head_ix + 1) % QueueDepth;
          fill--;
          head_start = (fill != 0) ? slot_start[head_ix] : total_len;
          o.status   = ST_OK;
        end
      end
      OP_QUERY: begin
        if (r.entry_number != 0 && r.entry_number <= fill) begin
          ix               = (head_ix + r.entry_number - 1) % QueueDepth;
          o.start_position = slot_start[ix] - head_start;
          o.status         = ST_OK;
        end
      end
      default: begin
        // Unused operation code: rejected, nothing changes.
      end
    endcase
    return o;
  endfunction

  // Compare each response with the oldest one owed, then log a new request.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      total_len     = '0;
      head_start    = '0;
      head_ix       = 0;
      tail_ix       = 0;
      fill          = 0;
      owed_rsp_q.delete();
      failures_o    = 0;
      checked_o     = 0;
      full_seen_o   = 0;
      reject_seen_o = 0;
      pending_o    <= 0;
    end else begin
      if (done_i === 1'b1) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = owed_rsp_q.pop_front();
          checked_o++;
          if (rsp_i.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", rsp_i.status, want.status));
          end
          if (rsp_i.start_position !== want.start_position) begin
            report_mismatch($sformatf("start_position %0h, want %0h",
                                      rsp_i.start_position, want.start_position));
          end
        end
      end else if (done_i !== 1'b0) begin
        report_mismatch("done strobe is unknown");
      end

      if (start_i && !busy_i) begin
        want = track_offset(req_i);
        if (want.status == ST_FULL) full_seen_o++;
        if (want.status == ST_EMPTY) reject_seen_o++;
        owed_rsp_q = {owed_rsp_q, want};
      end
      pending_o <= owed_rsp_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qpot_pkg::*;

  // Operation code that the block does not define.
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int MaxEntry = (1 << EntryW) - 1;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  int unsigned pending;
  int unsigned failures;
  int unsigned checked;
  int unsigned full_seen;
  int unsigned reject_seen;

  // Stimulus bookkeeping: expected queue level and idle pattern.
  int unsigned level;
  int unsigned peak;
  int unsigned sent;
  bit          burst;
  int          burst_left;

  queue_prefix_offset_tracker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  qpot_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .done_i        (done_o),
    .rsp_i         (rsp_o),
    .pending_o     (pending),
    .failures_o    (failures),
    .checked_o     (checked),
    .full_seen_o   (full_seen),
    .reject_seen_o (reject_seen)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Lengths mix the extremes with small and fully random values.
  function automatic logic [LenW-1:0] pick_length();
    logic [LenW-1:0] len;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = '1;
      2, 3, 4: len = LenW'($urandom_range(1, 1000));
      default: len = $urandom;
    endcase
    return len;
  endfunction

  // Issues one request after a random idle gap and waits until it is taken.
  task automatic send(input logic [OpW-1:0] op, input logic [LenW-1:0] len,
                      input logic [EntryW-1:0] entry);
    int   gap;
    req_t r;
    if (burst_left <= 0) begin
      burst      = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(8, 40);
    end
    burst_left--;
    gap            = burst ? 0 : $urandom_range(0, 15);
    r.operation    = op;
    r.length       = len;
    r.entry_number = entry;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sent++;
    if (op == OP_PUSH && level < QueueDepth) level++;
    if (op == OP_POP && level > 0) level--;
    if (level > peak) peak = level;
  endtask

  // Holds requests back until every response owed has come.
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random traffic: mostly pushes, pops and in-range queries, plus some noise.
  task automatic mixed_traffic(input int count, input int push_pct, input int pop_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        send(OP_PUSH, pick_length(), EntryW'($urandom));
      end else if (roll < push_pct + pop_pct) begin
        send(OP_POP, $urandom, EntryW'($urandom));
      end else if (roll < 94) begin
        send(OP_QUERY, $urandom,
             (level == 0) ? EntryW'(1) : EntryW'($urandom_range(1, level)));
      end else begin
        case ($urandom_range(0, 3))
          0:       send(OpUnused, $urandom, EntryW'($urandom));
          1:       send(OP_QUERY, $urandom, '0);
          2:       send(OP_QUERY, $urandom, EntryW'(level + 1));
          default: send(OP_QUERY, $urandom, EntryW'($urandom_range(0, MaxEntry)));
        endcase
      end
    end
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    level      = 0;
    peak       = 0;
    sent       = 0;
    burst      = 1'b0;
    burst_left = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty queue rejects, length extremes, query range edges.
    send(OP_POP, '0, '0);
    send(OP_QUERY, '0, EntryW'(1));
    send(OpUnused, '1, '1);
    send(OP_PUSH, '0, '0);
    send(OP_PUSH, '1, '0);
    send(OP_PUSH, LenW'(1), '0);
    send(OP_PUSH, 32'hA5A5_5A5A, '0);
    send(OP_QUERY, '0, '0);
    for (int k = 1; k <= 5; k++) begin
      send(OP_QUERY, '0, EntryW'(k));
    end
    send(OP_QUERY, '1, EntryW'(MaxEntry));
    send(OP_POP, '0, '0);
    send(OP_QUERY, '0, EntryW'(1));
    send(OP_QUERY, '0, EntryW'(3));
    send(OP_POP, '0, '0);
    send(OP_POP, '0, '0);
    send(OP_POP, '0, '0);
    send(OP_POP, '0, '0);
    send(OP_PUSH, LenW'(7), '0);
    send(OP_QUERY, '0, EntryW'(1));
    wait_drained();

    // Random traffic from a nearly empty queue.
    mixed_traffic(200, 45, 25);
    wait_drained();

    // Fill to capacity, then hit the full case and the top query entries.
    while (level < QueueDepth) begin
      send(OP_PUSH, pick_length(), EntryW'($urandom));
    end
    for (int i = 0; i < 3; i++) begin
      send(OP_PUSH, pick_length(), '0);
    end
    send(OP_QUERY, '0, EntryW'(QueueDepth));
    send(OP_QUERY, '0, EntryW'(QueueDepth + 1));
    send(OP_QUERY, '0, EntryW'(1));
    wait_drained();

    // Random traffic near full, so the ring wraps and drains again.
    mixed_traffic(250, 35, 40);

    // Let the last responses come back.
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d responses; queue level peaked at %0d of %0d.",
             sent, checked, peak, QueueDepth);
    $display("Pushes refused as full: %0d; pops, queries and bad codes rejected: %0d.",
             full_seen, reject_seen);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: queue_prefix_offset_tracker_unit.f
rtl/qpot_pkg.sv
rtl/qpot_front.sv
rtl/qpot_back.sv
rtl/queue_prefix_offset_tracker_unit.sv
tb/qpot_checker.sv
tb/tb_top.sv
